[design/key_sequence_trie_matcher_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the key sequence trie matcher
// Concurrent checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef KEY_SEQUENCE_TRIE_MATCHER_UNIT_DEFINES_SVH
`define KEY_SEQUENCE_TRIE_MATCHER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/ksm_pkg.sv]
// ---------------------------------------------------------------------------
// ksm_pkg
// Shared types and constants of the key sequence trie matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package ksm_pkg;

  typedef enum logic {
    OP_KEY    = 1'b0,
    OP_INSERT = 1'b1
  } ksm_op_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } ksm_status_t;

  localparam logic [7:0]  KEY_ZERO    = 8'h30;
  localparam logic [7:0]  KEY_NINE    = 8'h39;
  localparam logic [3:0]  COUNT_RADIX = 4'd10;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic alloc;
    logic mark_leaf;
  } ksm_wr_ctl_t;

  typedef struct packed {
    logic step;
    logic at_root;
    logic clear;
  } ksm_count_ctl_t;

endpackage

`default_nettype wire

[design/ksm_channel_if.sv]
// ---------------------------------------------------------------------------
// ksm channel interfaces
// Valid/ready channels for key/insert items and match results.
// ---------------------------------------------------------------------------
`default_nettype none

interface ksm_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] key;
  logic       last_key;
  logic [7:0] command_id;

  modport source (output valid, op, key, last_key, command_id, input ready);
  modport sink   (input valid, op, key, last_key, command_id, output ready);
endinterface

interface ksm_out_if;
  logic        valid;
  logic        ready;
  logic        handled;
  logic        fired;
  logic [7:0]  command;
  logic [15:0] count;
  logic        status;

  modport source (output valid, handled, fired, command, count, status, input ready);
  modport sink   (input valid, handled, fired, command, count, status, output ready);
endinterface

`default_nettype wire

[design/ksm_trie.sv]
// ---------------------------------------------------------------------------
// ksm_trie
// Node table with two parallel child lookups and one write port.
// ---------------------------------------------------------------------------
`default_nettype none
`include "key_sequence_trie_matcher_unit_defines.svh"

module ksm_trie
  import ksm_pkg::*;
#(
  parameter int NODES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [$clog2(NODES)-1:0]      parent_a,
  input  wire logic [7:0]                    key,
  output logic                               a_hit,
  output logic [$clog2(NODES)-1:0]           a_idx,
  output logic                               a_leaf,
  output logic [7:0]                         a_command,
  output logic                               b_hit,
  output logic [$clog2(NODES)-1:0]           b_idx,
  output logic                               b_leaf,
  output logic [7:0]                         b_command,
  input  wire ksm_wr_ctl_t                   wr_ctl,
  input  wire logic [$clog2(NODES)-1:0]      wr_idx,
  input  wire logic [$clog2(NODES)-1:0]      wr_parent,
  input  wire logic [7:0]                    wr_key,
  input  wire logic [7:0]                    wr_command,
  output logic [$clog2(NODES+1)-1:0]         nodes_used
);

  localparam int IW = $clog2(NODES);
  localparam int UW = $clog2(NODES + 1);

  logic [IW-1:0]    node_parent  [NODES];
  logic [7:0]       node_key     [NODES];
  logic [7:0]       node_command [NODES];
  logic [NODES-1:0] node_leaf;
  logic [NODES-1:0] hit_a;
  logic [NODES-1:0] hit_b;

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      hit_a[i] = (i != 0) && (UW'(i) < nodes_used) &&
                 (node_parent[i] == parent_a) && (node_key[i] == key);
      hit_b[i] = (i != 0) && (UW'(i) < nodes_used) &&
                 (node_parent[i] == '0) && (node_key[i] == key);
    end
  end

  always_comb begin
    a_idx     = '0;
    b_idx     = '0;
    a_command = '0;
    b_command = '0;
    for (int i = 0; i < NODES; i++) begin
      a_idx     = a_idx | (hit_a[i] ? IW'(i) : '0);
      b_idx     = b_idx | (hit_b[i] ? IW'(i) : '0);
      a_command = a_command | (hit_a[i] ? node_command[i] : 8'h00);
      b_command = b_command | (hit_b[i] ? node_command[i] : 8'h00);
    end
    a_hit  = |hit_a;
    b_hit  = |hit_b;
    a_leaf = |(hit_a & node_leaf);
    b_leaf = |(hit_b & node_leaf);
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.alloc) begin
      node_parent[wr_idx] <= wr_parent;
      node_key[wr_idx]    <= wr_key;
    end
    if (wr_ctl.mark_leaf) begin
      node_command[wr_idx] <= wr_command;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_leaf  <= '0;
      nodes_used <= UW'(1);
    end else begin
      if (wr_ctl.mark_leaf) begin
        node_leaf[wr_idx] <= 1'b1;
      end else if (wr_ctl.alloc) begin
        node_leaf[wr_idx] <= 1'b0;
      end
      if (wr_ctl.alloc) begin
        nodes_used <= nodes_used + 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_hit_a_unique, 1'b1, $onehot0(hit_a))
  `ASSERT_IMPLIES(a_hit_b_unique, 1'b1, $onehot0(hit_b))
  `ASSERT_IMPLIES(a_used_range, 1'b1, (nodes_used != '0) && (nodes_used <= UW'(NODES)))

endmodule

`default_nettype wire

[design/ksm_count.sv]
// ---------------------------------------------------------------------------
// ksm_count
// Decimal repeat-count register with saturating digit accumulation.
// ---------------------------------------------------------------------------
`default_nettype none

module ksm_count
  import ksm_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ksm_count_ctl_t ctl,
  input  wire logic [7:0]     key,
  output logic                take,
  output logic [15:0]         pending,
  output logic [15:0]         next_count
);

  logic        digit;
  logic        zero_key;
  logic [3:0]  digit_val;
  logic [19:0] scaled;

  always_comb begin
    digit      = (key >= KEY_ZERO) && (key <= KEY_NINE);
    zero_key   = (key == KEY_ZERO) && (pending == '0) && ctl.at_root;
    take       = digit && !zero_key;
    digit_val  = 4'(key - KEY_ZERO);
    scaled     = 20'(pending) * 20'(COUNT_RADIX) + 20'(digit_val);
    next_count = (scaled > 20'(COUNT_MAX)) ? COUNT_MAX : scaled[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (ctl.step) begin
      if (take) begin
        pending <= next_count;
      end else if (ctl.clear) begin
        pending <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[design/key_sequence_trie_matcher_unit.sv]
// ---------------------------------------------------------------------------
// key_sequence_trie_matcher_unit
// Matches keystrokes against a trie of key sequences with a repeat count.
// ---------------------------------------------------------------------------
//  channel  | dir | fields                              | transaction
//  ---------+-----+-------------------------------------+-----------------------
//  item     | in  | op, key, last_key, command_id       | key press or insert
//  result   | out | handled, fired, command, count,     | one per item
//           |     | status                              |
//
//  One item per cycle while results are taken: an item sits in the input
//  register, then one pass through the node compare (current path and root
//  retry) writes the result register and the trie state in the same cycle.
//  A waiting result holds the item in the input register; item.ready then
//  stays low until result.ready.
//  rst clears the cursors, the count and the leaf marks and sets the node fill
//  count back to the root alone; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none
`include "key_sequence_trie_matcher_unit_defines.svh"

module key_sequence_trie_matcher_unit
  import ksm_pkg::*;
#(
  parameter int NODES = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  ksm_in_if.sink    item,
  ksm_out_if.source result
);

  localparam int IW = $clog2(NODES);
  localparam int UW = $clog2(NODES + 1);

  // input register
  logic       item_valid;
  logic       op_q;
  logic [7:0] key_q;
  logic       last_q;
  logic [7:0] cmd_q;

  // trie state
  logic [IW-1:0] match_cursor;
  logic [IW-1:0] match_cursor_next;
  logic [IW-1:0] build_cursor;
  logic [IW-1:0] build_cursor_next;
  logic          build_failed;
  logic          build_failed_next;

  // result register
  logic        res_valid;
  logic        res_handled;
  logic        res_fired;
  logic [7:0]  res_command;
  logic [15:0] res_count;
  logic        res_status;

  logic          proc;
  logic          ins_op;
  logic [IW-1:0] parent_a;
  logic          a_hit;
  logic [IW-1:0] a_idx;
  logic          a_leaf;
  logic [7:0]    a_command;
  logic          b_hit;
  logic [IW-1:0] b_idx;
  logic          b_leaf;
  logic [7:0]    b_command;
  ksm_wr_ctl_t   wr_ctl;
  logic [IW-1:0] wr_idx;
  logic [UW-1:0] nodes_used;

  ksm_count_ctl_t count_ctl;
  logic           take;
  logic [15:0]    pending;
  logic [15:0]    next_count;

  logic          fail_now;
  logic          failed_eff;
  logic          found;
  logic [IW-1:0] found_idx;
  logic          found_leaf;
  logic [7:0]    found_command;
  logic          fire_raw;
  logic          handled_c;
  logic          fired_c;
  logic [7:0]    command_c;
  logic [15:0]   count_c;

  assign proc        = item_valid && (!res_valid || result.ready);
  assign item.ready  = !item_valid || proc;
  assign ins_op      = (op_q == OP_INSERT);
  assign parent_a    = ins_op ? build_cursor : match_cursor;

  ksm_trie #(.NODES(NODES)) u_trie (
    .clk        (clk),
    .rst        (rst),
    .parent_a   (parent_a),
    .key        (key_q),
    .a_hit      (a_hit),
    .a_idx      (a_idx),
    .a_leaf     (a_leaf),
    .a_command  (a_command),
    .b_hit      (b_hit),
    .b_idx      (b_idx),
    .b_leaf     (b_leaf),
    .b_command  (b_command),
    .wr_ctl     (wr_ctl),
    .wr_idx     (wr_idx),
    .wr_parent  (build_cursor),
    .wr_key     (key_q),
    .wr_command (cmd_q),
    .nodes_used (nodes_used)
  );

  ksm_count u_count (
    .clk        (clk),
    .rst        (rst),
    .ctl        (count_ctl),
    .key        (key_q),
    .take       (take),
    .pending    (pending),
    .next_count (next_count)
  );

  // insert path
  always_comb begin
    wr_ctl    = '0;
    wr_idx    = a_idx;
    fail_now  = 1'b0;
    if (!build_failed && !a_hit) begin
      if (nodes_used < UW'(NODES)) begin
        wr_idx       = nodes_used[IW-1:0];
        wr_ctl.alloc = proc && ins_op;
      end else begin
        fail_now = 1'b1;
      end
    end
    failed_eff       = build_failed || fail_now;
    wr_ctl.mark_leaf = proc && ins_op && last_q && !failed_eff;
    if (last_q) begin
      build_cursor_next = '0;
      build_failed_next = 1'b0;
    end else begin
      build_cursor_next = failed_eff ? build_cursor : wr_idx;
      build_failed_next = failed_eff;
    end
  end

  // key path: current path first, root retry after a partial match
  always_comb begin
    found         = 1'b0;
    found_idx     = '0;
    found_leaf    = 1'b0;
    found_command = '0;
    if (a_hit) begin
      found         = 1'b1;
      found_idx     = a_idx;
      found_leaf    = a_leaf;
      found_command = a_command;
    end else if (match_cursor != '0 && b_hit) begin
      found         = 1'b1;
      found_idx     = b_idx;
      found_leaf    = b_leaf;
      found_command = b_command;
    end
    fire_raw          = found && found_leaf;
    match_cursor_next = (found && !found_leaf) ? found_idx : '0;

    count_ctl.step    = proc && !ins_op;
    count_ctl.at_root = (match_cursor == '0);
    count_ctl.clear   = fire_raw;

    if (ins_op) begin
      handled_c = 1'b0;
      fired_c   = 1'b0;
      command_c = '0;
      count_c   = pending;
    end else begin
      handled_c = take || found;
      fired_c   = !take && fire_raw;
      command_c = fired_c ? found_command : 8'h00;
      count_c   = take ? next_count : pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      match_cursor <= '0;
      build_cursor <= '0;
      build_failed <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        item_valid <= 1'b1;
      end else if (proc) begin
        item_valid <= 1'b0;
      end
      if (proc) begin
        res_valid <= 1'b1;
        if (ins_op) begin
          build_cursor <= build_cursor_next;
          build_failed <= build_failed_next;
        end else if (!take) begin
          match_cursor <= match_cursor_next;
        end
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      op_q   <= item.op;
      key_q  <= item.key;
      last_q <= item.last_key;
      cmd_q  <= item.command_id;
    end
    if (proc) begin
      res_handled <= handled_c;
      res_fired   <= fired_c;
      res_command <= command_c;
      res_count   <= count_c;
      res_status  <= (ins_op && failed_eff) ? STATUS_FULL : STATUS_OK;
    end
  end

  assign result.valid   = res_valid;
  assign result.handled = res_handled;
  assign result.fired   = res_fired;
  assign result.command = res_command;
  assign result.count   = res_count;
  assign result.status  = res_status;

  `ASSERT_IMPLIES(a_insert_quiet, proc && ins_op, !handled_c && !fired_c)
  `ASSERT_NEXT(a_fire_clears, proc && fired_c, (match_cursor == '0) && (pending == '0))
  `ASSERT_NEXT(a_last_resets_build, proc && ins_op && last_q, (build_cursor == '0) && !build_failed)
  `ASSERT_IMPLIES(a_full_not_handled, res_valid && res_status, !res_handled && !res_fired)

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key sequence trie matcher testbench
// Loads key sequences into the trie and types keystrokes against it, with
// repeat counts, misses, retries and a full node table. A scoreboard class
// keeps its own copy of the trie and the count, predicts the response to
// every accepted item and compares it with what the block returns.
// ---------------------------------------------------------------------------

module testbench;
  import ksm_pkg::*;

  localparam int NODES        = 32;
  localparam int IDX_W        = $clog2(NODES);
  localparam int TOTAL_ITEMS  = 1350;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 1000;
  localparam int SETTLE       = 4;
  localparam int KNOWN_MAX    = 64;

  typedef logic [IDX_W-1:0] node_idx_t;
  typedef logic [3:0][7:0]  keyseq_t;

  typedef struct packed {
    logic        handled;
    logic        fired;
    logic [7:0]  command;
    logic [15:0] count;
    ksm_status_t status;
  } response_t;

  class keymap_scoreboard;
    node_idx_t   parent_of [NODES];
    logic [7:0]  key_of    [NODES];
    bit          leaf_at   [NODES];
    logic [7:0]  cmd_at    [NODES];
    logic [5:0]  used;
    node_idx_t   match_at;
    node_idx_t   build_at;
    bit          build_broken;
    logic [15:0] repeat_count;
    response_t   awaited[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned fired_total;
    int unsigned unhandled_total;
    int unsigned refused_total;

    function new();
      foreach (leaf_at[i]) leaf_at[i] = 1'b0;
      used         = 6'd1;
      match_at     = '0;
      build_at     = '0;
      build_broken = 1'b0;
      repeat_count = '0;
    endfunction

    function node_idx_t child_of(input node_idx_t p, input logic [7:0] k);
      for (int i = 1; i < used; i++) begin
        if (parent_of[i] == p && key_of[i] == k) return node_idx_t'(i);
      end
      return '0;
    endfunction

    function response_t predict_response(input ksm_op_t op, input logic [7:0] key,
                                         input logic last_k, input logic [7:0] cmd);
      response_t   r;
      node_idx_t   c;
      int unsigned v;
      r = '0;
      r.status = STATUS_OK;
      if (op == OP_INSERT) begin
        if (!build_broken) begin
          c = child_of(build_at, key);
          if (c == 0) begin
            if (used < NODES) begin
              c = node_idx_t'(used);
              parent_of[c] = build_at;
              key_of[c]    = key;
              leaf_at[c]   = 1'b0;
              cmd_at[c]    = '0;
              used++;
            end else begin
              build_broken = 1'b1;
            end
          end
          if (!build_broken) build_at = c;
        end
        r.status = build_broken ? STATUS_FULL : STATUS_OK;
        if (last_k) begin
          if (!build_broken && build_at != 0) begin
            leaf_at[build_at] = 1'b1;
            cmd_at[build_at]  = cmd;
          end
          build_at     = '0;
          build_broken = 1'b0;
        end
        r.count = repeat_count;
      end else if (key >= KEY_ZERO && key <= KEY_NINE &&
                   !(key == KEY_ZERO && repeat_count == 0 && match_at == 0)) begin
        v = repeat_count * COUNT_RADIX + key - KEY_ZERO;
        repeat_count = (v > COUNT_MAX) ? COUNT_MAX : v[15:0];
        r.handled = 1'b1;
        r.count   = repeat_count;
      end else begin
        r.count = repeat_count;
        c = child_of(match_at, key);
        if (c == 0 && match_at != 0) begin
          match_at = '0;
          c = child_of('0, key);
        end
        if (c != 0) begin
          r.handled = 1'b1;
          match_at  = c;
          if (leaf_at[c]) begin
            r.fired      = 1'b1;
            r.command    = cmd_at[c];
            match_at     = '0;
            repeat_count = '0;
          end
        end
      end
      return r;
    endfunction

    function void apply_item(input ksm_op_t op, input logic [7:0] key,
                             input logic last_k, input logic [7:0] cmd);
      response_t r;
      r = predict_response(op, key, last_k, cmd);
      if (r.fired) fired_total++;
      if (op == OP_KEY && !r.handled) unhandled_total++;
      if (r.status == STATUS_FULL) refused_total++;
      awaited.push_back(r);
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    task report(input string what);
      errors++;
      if (errors <= 40) $display("[%0t] response %0d: %s", $time, checked, what);
    endtask

    task check_result(input response_t got);
      response_t want;
      if (awaited.size() == 0) begin
        report("response with no item outstanding");
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.handled !== want.handled)
        report($sformatf("handled %0b, expected %0b", got.handled, want.handled));
      if (got.fired !== want.fired)
        report($sformatf("fired %0b, expected %0b", got.fired, want.fired));
      if (got.command !== want.command)
        report($sformatf("command %0h, expected %0h", got.command, want.command));
      if (got.count !== want.count)
        report($sformatf("count %0d, expected %0d", got.count, want.count));
      if (got.status !== want.status)
        report($sformatf("status %0b, expected %0b", got.status, want.status));
    endtask
  endclass

  logic clk;
  logic rst;

  ksm_in_if  item_ch ();
  ksm_out_if result_ch ();

  key_sequence_trie_matcher_unit #(.NODES(NODES)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  keymap_scoreboard keymap;
  bit      no_gaps;
  bit      hold_results;
  int      items_sent;
  keyseq_t known_seq [KNOWN_MAX];
  int      known_len [KNOWN_MAX];
  int      known_n;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    response_t got;
    if (!rst && item_ch.valid && item_ch.ready)
      keymap.apply_item(ksm_op_t'(item_ch.op), item_ch.key, item_ch.last_key,
                        item_ch.command_id);
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.handled = result_ch.handled;
      got.fired   = result_ch.fired;
      got.command = result_ch.command;
      got.count   = result_ch.count;
      got.status  = ksm_status_t'(result_ch.status);
      keymap.check_result(got);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return KEY_ZERO;
    if (r < 20) return 8'($urandom);
    return 8'("a" + $urandom_range(0, 7));
  endfunction

  initial begin : result_drain
    int stall;
    stall = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
        result_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
        stall = no_gaps ? 0 : pick_gap();
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input ksm_op_t op, input logic [7:0] key,
                           input logic last_k, input logic [7:0] cmd);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= op;
    item_ch.key        <= key;
    item_ch.last_key   <= last_k;
    item_ch.command_id <= cmd;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic press_key(input logic [7:0] key);
    send_item(OP_KEY, key, 1'($urandom), 8'($urandom));
  endtask

  task automatic insert_seq(input keyseq_t s, input int len, input logic [7:0] cmd);
    int slot;
    for (int i = 0; i < len; i++)
      send_item(OP_INSERT, s[i], i == len - 1, (i == len - 1) ? cmd : 8'($urandom));
    if (known_n < KNOWN_MAX) begin
      slot = known_n;
      known_n++;
    end else begin
      slot = $urandom_range(0, KNOWN_MAX - 1);
    end
    known_seq[slot] = s;
    known_len[slot] = len;
  endtask

  task automatic type_count(input int digits);
    press_key(8'(KEY_ZERO + $urandom_range(1, 9)));
    repeat (digits - 1) press_key(8'(KEY_ZERO + $urandom_range(0, 9)));
  endtask

  initial begin : stimulus
    keyseq_t s;
    int      r;
    int      c;
    int      pick;
    int      len;
    int      round;
    int      burst_left;

    keymap       = new();
    no_gaps      = 1'b0;
    hold_results = 1'b0;
    items_sent   = 0;
    known_n      = 0;
    round        = 0;
    burst_left   = 0;

    rst                = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.op         = OP_KEY;
    item_ch.key        = '0;
    item_ch.last_key   = 1'b0;
    item_ch.command_id = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty trie, then zero as a key, leaves past a leaf, overwrite, counts
    press_key(8'h00);
    press_key(KEY_ZERO);
    insert_seq({24'h0, KEY_ZERO}, 1, 8'hFF);
    press_key(KEY_ZERO);
    insert_seq({16'h0, "g", "g"}, 2, 8'h01);
    insert_seq({24'h0, "d"}, 1, 8'h00);
    insert_seq({16'h0, "w", "d"}, 2, 8'h22);
    insert_seq({16'h0, "g", "g"}, 2, 8'hFE);
    press_key(8'(KEY_ZERO + 3));
    press_key(KEY_ZERO);
    press_key("g");
    press_key("g");
    press_key("g");
    press_key(8'(KEY_ZERO + 5));
    press_key("d");
    repeat (6) press_key(KEY_NINE);
    press_key(8'hFF);
    press_key("d");

    while (items_sent < TOTAL_ITEMS) begin
      round++;
      if (round == 120 || round == 400) begin
        hold_results = 1'b1;
        burst_left   = 30;
      end
      if (round == 250) begin
        no_gaps = 1'b0;
        item_ch.valid <= 1'b0;
        while (keymap.outstanding() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
      end
      no_gaps = burst_left > 0 || (round % 100) >= 80;
      if (burst_left > 0) burst_left--;

      r = $urandom_range(0, 99);
      if (r < 10) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++) s[i] = pick_key();
        insert_seq(s, len, 8'($urandom));
      end else if (r < 14) begin
        pick = $urandom_range(0, known_n - 1);
        insert_seq(known_seq[pick], known_len[pick], 8'($urandom));
      end else if (r < 16) begin
        repeat ($urandom_range(1, 2)) send_item(OP_INSERT, pick_key(), 1'b0, 8'($urandom));
      end else if (r < 66) begin
        pick = $urandom_range(0, known_n - 1);
        s    = known_seq[pick];
        len  = known_len[pick];
        c    = $urandom_range(0, 99);
        if (c < 35) type_count($urandom_range(1, 3));
        else if (c < 40) type_count($urandom_range(5, 7));
        if ($urandom_range(0, 99) < 15) s[$urandom_range(0, len - 1)] = pick_key();
        if ($urandom_range(0, 99) < 10 && len > 1) len--;
        for (int i = 0; i < len; i++) press_key(s[i]);
      end else if (r < 82) begin
        press_key(pick_key());
      end else if (r < 92) begin
        press_key(8'($urandom));
      end else begin
        press_key(8'(KEY_ZERO + $urandom_range(0, 9)));
      end
    end

    item_ch.valid <= 1'b0;
    while (keymap.outstanding() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Sent %0d items, checked %0d responses: %0d commands fired, %0d keys unhandled.",
             items_sent, keymap.checked, keymap.fired_total, keymap.unhandled_total);
    $display("Inserts refused on a full table: %0d; trie ended with %0d of %0d nodes.",
             keymap.refused_total, keymap.used, NODES);
    if (keymap.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
